/* sv/char_lcd_nibble_sequencer_core_defines.svh */
// Assertion macros used by the LCD nibble sequencer top level
`ifndef CHAR_LCD_NIBBLE_SEQUENCER_CORE_DEFINES_SVH
`define CHAR_LCD_NIBBLE_SEQUENCER_CORE_DEFINES_SVH

// Implication checked on every rising edge, masked while reset is asserted
`define CLCD_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Same, with the property checked also during reset
`define CLCD_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

/* sv/clcd_pkg.sv */
// Types, opcodes and microcode helpers for the LCD nibble sequencer
package clcd_pkg;

	localparam int PC_W     = 6;
	localparam int HOLD_W   = 17;
	localparam int ROM_LAST = 60;

	typedef enum logic [2:0] {
		OP_CMD   = 3'd0,
		OP_DATA  = 3'd1,
		OP_GOTO  = 3'd2,
		OP_CLEAR = 3'd3,
		OP_INIT  = 3'd4,
		OP_SLOT  = 3'd5
	} op_t;

	// Program entry points in the microcode table
	localparam logic [PC_W-1:0] ENTRY_BYTE  = 6'd0;
	localparam logic [PC_W-1:0] ENTRY_CLEAR = 6'd6;
	localparam logic [PC_W-1:0] ENTRY_INIT  = 6'd18;

	typedef enum logic [1:0] {
		NS_HI    = 2'd0,
		NS_LO    = 2'd1,
		NS_CONST = 2'd2
	} nsel_t;

	typedef enum logic [2:0] {
		H_10    = 3'd0,
		H_200   = 3'd1,
		H_700   = 3'd2,
		H_80000 = 3'd3,
		H_20200 = 3'd4,
		H_10200 = 3'd5,
		H_10700 = 3'd6,
		H_5700  = 3'd7
	} hold_t;

	typedef struct packed {
		logic       en;
		nsel_t      nsel;
		logic [3:0] nconst;
		hold_t      hold;
		logic       last;
	} uword_t;

	typedef struct packed {
		logic       fire;
		logic       rs;
		logic [7:0] byte_val;
	} seq_status_t;

	typedef struct packed {
		logic [2:0] op;
		logic [7:0] byte_value;
		logic [1:0] row;
		logic [5:0] column;
		logic [2:0] char_slot;
	} in_item_t;

	typedef struct packed {
		logic              reg_select;
		logic              enable_pin;
		logic [3:0]        data_nibble;
		logic [HOLD_W-1:0] hold_us;
		logic              last;
	} out_item_t;

	function automatic uword_t uw(logic en, nsel_t nsel, logic [3:0] nconst,
			hold_t hold, logic last);
		uword_t w;
		w.en     = en;
		w.nsel   = nsel;
		w.nconst = nconst;
		w.hold   = hold;
		w.last   = last;
		return w;
	endfunction

	function automatic logic [HOLD_W-1:0] hold_value(hold_t h);
		logic [HOLD_W-1:0] v;
		case (h)
			H_10:    v = 17'd10;
			H_200:   v = 17'd200;
			H_700:   v = 17'd700;
			H_80000: v = 17'd80000;
			H_20200: v = 17'd20200;
			H_10200: v = 17'd10200;
			H_10700: v = 17'd10700;
			H_5700:  v = 17'd5700;
			default: v = 17'd10;
		endcase
		return v;
	endfunction

	function automatic logic [7:0] line_base(logic [1:0] row);
		logic [7:0] b;
		case (row)
			2'd0:    b = 8'h00;
			2'd1:    b = 8'h40;
			2'd2:    b = 8'h14;
			2'd3:    b = 8'h54;
			default: b = 8'h00;
		endcase
		return b;
	endfunction

endpackage

/* sv/char_lcd_nibble_sequencer_core.sv */
// Top level of the character LCD 4-bit nibble sequencer
// A request is latched into the step counter; each pin state is then registered in the output register.
// Throughput: one pin state per cycle from the microcode step counter while the output
// is not stalled; a request occupies it until the last step of its program issues.
// A new request is taken the cycle after the last step issues; op 6 and 7 are taken and dropped.
// Reset (arst_n low) idles the step counter and empties the output register.
`include "char_lcd_nibble_sequencer_core_defines.svh"
module char_lcd_nibble_sequencer_core import clcd_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	output logic      in_stall,
	input  in_item_t  in_item,
	output logic      out_valid,
	input  logic      out_stall,
	output out_item_t out_item
);

	logic            busy;
	logic [PC_W-1:0] pc;
	uword_t          word;
	seq_status_t     status;
	logic            out_ready;

	clcd_ucode_rom u_rom (
		.pc   (pc),
		.word (word)
	);

	clcd_seq_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_item   (in_item),
		.out_ready (out_ready),
		.word      (word),
		.busy      (busy),
		.pc        (pc),
		.status    (status)
	);

	clcd_out_stage u_out (
		.clk       (clk),
		.arst_n    (arst_n),
		.word      (word),
		.status    (status),
		.out_stall (out_stall),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.out_item  (out_item)
	);

	assign in_stall = busy;

	`CLCD_ASSERT(a_start_busy, in_valid && !busy && in_item.op <= OP_SLOT |=> busy, "no start")
	`CLCD_ASSERT(a_pc_range, busy |-> pc <= PC_W'(ROM_LAST), "step counter out of table")
	`CLCD_ASSERT(a_last_idle, status.fire && word.last |=> !busy, "busy after last step")
	`CLCD_ASSERT(a_last_low, out_valid && out_item.last |-> !out_item.enable_pin, "enable high at end")

endmodule

/* sv/clcd_ucode_rom.sv */
// Microcode table: one control word per pin state
module clcd_ucode_rom import clcd_pkg::*; (
	input  logic [PC_W-1:0] pc,
	output uword_t          word
);

	always_comb begin
		case (pc)
			// one byte from the latched value
			6'd0:  word = uw(1'b0, NS_HI,    4'h0, H_10,    1'b0);
			6'd1:  word = uw(1'b1, NS_HI,    4'h0, H_10,    1'b0);
			6'd2:  word = uw(1'b0, NS_HI,    4'h0, H_200,   1'b0);
			6'd3:  word = uw(1'b0, NS_LO,    4'h0, H_10,    1'b0);
			6'd4:  word = uw(1'b1, NS_LO,    4'h0, H_10,    1'b0);
			6'd5:  word = uw(1'b0, NS_LO,    4'h0, H_700,   1'b1);
			// clear: 0x01 then home 0x80
			6'd6:  word = uw(1'b0, NS_CONST, 4'h0, H_10,    1'b0);
			6'd7:  word = uw(1'b1, NS_CONST, 4'h0, H_10,    1'b0);
			6'd8:  word = uw(1'b0, NS_CONST, 4'h0, H_200,   1'b0);
			6'd9:  word = uw(1'b0, NS_CONST, 4'h1, H_10,    1'b0);
			6'd10: word = uw(1'b1, NS_CONST, 4'h1, H_10,    1'b0);
			6'd11: word = uw(1'b0, NS_CONST, 4'h1, H_10700, 1'b0);
			6'd12: word = uw(1'b0, NS_CONST, 4'h8, H_10,    1'b0);
			6'd13: word = uw(1'b1, NS_CONST, 4'h8, H_10,    1'b0);
			6'd14: word = uw(1'b0, NS_CONST, 4'h8, H_200,   1'b0);
			6'd15: word = uw(1'b0, NS_CONST, 4'h0, H_10,    1'b0);
			6'd16: word = uw(1'b1, NS_CONST, 4'h0, H_10,    1'b0);
			6'd17: word = uw(1'b0, NS_CONST, 4'h0, H_5700,  1'b1);
			// power-up init: settle, three 0x3 strobes, 0x2 strobe
			6'd18: word = uw(1'b0, NS_CONST, 4'h0, H_80000, 1'b0);
			6'd19: word = uw(1'b0, NS_CONST, 4'h3, H_10,    1'b0);
			6'd20: word = uw(1'b1, NS_CONST, 4'h3, H_10,    1'b0);
			6'd21: word = uw(1'b0, NS_CONST, 4'h3, H_20200, 1'b0);
			6'd22: word = uw(1'b0, NS_CONST, 4'h3, H_10,    1'b0);
			6'd23: word = uw(1'b1, NS_CONST, 4'h3, H_10,    1'b0);
			6'd24: word = uw(1'b0, NS_CONST, 4'h3, H_20200, 1'b0);
			6'd25: word = uw(1'b0, NS_CONST, 4'h3, H_10,    1'b0);
			6'd26: word = uw(1'b1, NS_CONST, 4'h3, H_10,    1'b0);
			6'd27: word = uw(1'b0, NS_CONST, 4'h3, H_20200, 1'b0);
			6'd28: word = uw(1'b0, NS_CONST, 4'h2, H_10,    1'b0);
			6'd29: word = uw(1'b1, NS_CONST, 4'h2, H_10,    1'b0);
			6'd30: word = uw(1'b0, NS_CONST, 4'h2, H_10200, 1'b0);
			// init commands 0x01, 0x20, 0x01, 0x06, 0x0C
			6'd31: word = uw(1'b0, NS_CONST, 4'h0, H_10,    1'b0);
			6'd32: word = uw(1'b1, NS_CONST, 4'h0, H_10,    1'b0);
			6'd33: word = uw(1'b0, NS_CONST, 4'h0, H_200,   1'b0);
			6'd34: word = uw(1'b0, NS_CONST, 4'h1, H_10,    1'b0);
			6'd35: word = uw(1'b1, NS_CONST, 4'h1, H_10,    1'b0);
			6'd36: word = uw(1'b0, NS_CONST, 4'h1, H_700,   1'b0);
			6'd37: word = uw(1'b0, NS_CONST, 4'h2, H_10,    1'b0);
			6'd38: word = uw(1'b1, NS_CONST, 4'h2, H_10,    1'b0);
			6'd39: word = uw(1'b0, NS_CONST, 4'h2, H_200,   1'b0);
			6'd40: word = uw(1'b0, NS_CONST, 4'h0, H_10,    1'b0);
			6'd41: word = uw(1'b1, NS_CONST, 4'h0, H_10,    1'b0);
			6'd42: word = uw(1'b0, NS_CONST, 4'h0, H_700,   1'b0);
			6'd43: word = uw(1'b0, NS_CONST, 4'h0, H_10,    1'b0);
			6'd44: word = uw(1'b1, NS_CONST, 4'h0, H_10,    1'b0);
			6'd45: word = uw(1'b0, NS_CONST, 4'h0, H_200,   1'b0);
			6'd46: word = uw(1'b0, NS_CONST, 4'h1, H_10,    1'b0);
			6'd47: word = uw(1'b1, NS_CONST, 4'h1, H_10,    1'b0);
			6'd48: word = uw(1'b0, NS_CONST, 4'h1, H_700,   1'b0);
			6'd49: word = uw(1'b0, NS_CONST, 4'h0, H_10,    1'b0);
			6'd50: word = uw(1'b1, NS_CONST, 4'h0, H_10,    1'b0);
			6'd51: word = uw(1'b0, NS_CONST, 4'h0, H_200,   1'b0);
			6'd52: word = uw(1'b0, NS_CONST, 4'h6, H_10,    1'b0);
			6'd53: word = uw(1'b1, NS_CONST, 4'h6, H_10,    1'b0);
			6'd54: word = uw(1'b0, NS_CONST, 4'h6, H_700,   1'b0);
			6'd55: word = uw(1'b0, NS_CONST, 4'h0, H_10,    1'b0);
			6'd56: word = uw(1'b1, NS_CONST, 4'h0, H_10,    1'b0);
			6'd57: word = uw(1'b0, NS_CONST, 4'h0, H_200,   1'b0);
			6'd58: word = uw(1'b0, NS_CONST, 4'hC, H_10,    1'b0);
			6'd59: word = uw(1'b1, NS_CONST, 4'hC, H_10,    1'b0);
			6'd60: word = uw(1'b0, NS_CONST, 4'hC, H_700,   1'b1);
			// unused addresses stop the program
			default: word = uw(1'b0, NS_CONST, 4'h0, H_10, 1'b1);
		endcase
	end

endmodule

/* sv/clcd_seq_ctrl.sv */
// Step counter, request latch and program dispatch
module clcd_seq_ctrl import clcd_pkg::*; (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  in_item_t        in_item,
	input  logic            out_ready,
	input  uword_t          word,
	output logic            busy,
	output logic [PC_W-1:0] pc,
	output seq_status_t     status
);

	logic            busy_q;
	logic [PC_W-1:0] pc_q;
	logic            rs_q;
	logic [7:0]      byte_q;
	logic            accept;
	logic            advance;
	logic            op_ok;
	logic [PC_W-1:0] entry;
	logic [7:0]      byte_next;
	logic [7:0]      goto_addr;

	assign accept    = in_valid && !busy_q;
	assign advance   = busy_q && out_ready;
	assign goto_addr = line_base(in_item.row) + {2'b00, in_item.column};

	always_comb begin
		op_ok     = 1'b1;
		entry     = ENTRY_BYTE;
		byte_next = in_item.byte_value;
		case (in_item.op)
			OP_CMD, OP_DATA: begin
				byte_next = in_item.byte_value;
			end
			OP_GOTO: begin
				byte_next = 8'h80 | goto_addr;
			end
			OP_SLOT: begin
				byte_next = {2'b01, in_item.char_slot, 3'b000};
			end
			OP_CLEAR: begin
				entry = ENTRY_CLEAR;
			end
			OP_INIT: begin
				entry = ENTRY_INIT;
			end
			default: begin
				// unused opcode: take it and drop it
				op_ok = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pc_q   <= '0;
			rs_q   <= 1'b0;
			byte_q <= '0;
		end else if (accept && op_ok) begin
			busy_q <= 1'b1;
			pc_q   <= entry;
			rs_q   <= (in_item.op == OP_DATA);
			byte_q <= byte_next;
		end else if (advance) begin
			if (word.last) begin
				busy_q <= 1'b0;
			end else begin
				pc_q <= pc_q + PC_W'(1);
			end
		end
	end

	assign busy            = busy_q;
	assign pc              = pc_q;
	assign status.fire     = advance;
	assign status.rs       = rs_q;
	assign status.byte_val = byte_q;

endmodule

/* sv/clcd_out_stage.sv */
// Datapath and output register: forms one pin state per control word
module clcd_out_stage import clcd_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  uword_t      word,
	input  seq_status_t status,
	input  logic        out_stall,
	output logic        out_ready,
	output logic        out_valid,
	output out_item_t   out_item
);

	logic      valid_q;
	out_item_t item_q;
	out_item_t item_next;

	assign out_ready = !valid_q || !out_stall;

	always_comb begin
		item_next.reg_select = status.rs;
		item_next.enable_pin = word.en;
		case (word.nsel)
			NS_HI:    item_next.data_nibble = status.byte_val[7:4];
			NS_LO:    item_next.data_nibble = status.byte_val[3:0];
			NS_CONST: item_next.data_nibble = word.nconst;
			default:  item_next.data_nibble = word.nconst;
		endcase
		item_next.hold_us = hold_value(word.hold);
		item_next.last    = word.last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (status.fire) begin
			valid_q <= 1'b1;
		end else if (!out_stall) begin
			valid_q <= 1'b0;
		end
	end

	// payload register, no reset needed
	always_ff @(posedge clk) begin
		if (status.fire) begin
			item_q <= item_next;
		end
	end

	assign out_valid = valid_q;
	assign out_item  = item_q;

endmodule
